FILE: design/svpm_pkg.sv
// Shared types, constants and calibration table of the servo pulse mapper.
`default_nettype none
package svpm_pkg;

    localparam int JOINT_COUNT     = 12;
    localparam int ANGLE_FRAC_BITS = 12;

    localparam int OP_W     = 2;
    localparam int JOINT_W  = 4;
    localparam int ANGLE_W  = 15;
    localparam int AGE_W    = 16;
    localparam int PULSE_W  = 12;
    localparam int CHAN_W   = 4;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [AGE_W-1:0]   TIMEOUT_RST   = 16'd250;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd370;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2400;

    typedef enum logic [OP_W-1:0] {
        OP_CMD  = 2'd0,
        OP_TICK = 2'd1,
        OP_CTRL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT   = 2'd0,
        REG_PULSE_MIN = 2'd1,
        REG_PULSE_MAX = 2'd2
    } reg_t;

    // degrees per radian in Q16
    localparam int                DPR_W      = 23;
    localparam logic signed [22:0] RAD_TO_DEG_Q16 = 23'sd3754936;
    localparam int CENTER_DEG = 90;
    localparam int RANGE_DEG  = 180;

    localparam int DEG_FRAC = ANGLE_FRAC_BITS + 16;
    localparam int DEG_W    = DEG_FRAC + 8;
    localparam int PROD_W   = ANGLE_W + DPR_W;
    localparam int SUM_W    = (DEG_W + 2 > PROD_W + 1) ? DEG_W + 2 : PROD_W + 1;
    localparam int SPAN_W   = PULSE_W + 1;
    localparam int X_W      = DEG_W + 1 + SPAN_W;

    // floor division by 180: bias to nonnegative, drop two bits, then divide by 45
    localparam int               QV_W         = 22;
    localparam logic [QV_W-1:0]  DIV_BIAS     = QV_W'(RANGE_DEG * (1 << PULSE_W));
    localparam int               DIV_PRESHIFT = 2;
    localparam int               U_W          = QV_W - DIV_PRESHIFT;
    localparam int               RECIP_W      = 20;
    localparam logic [RECIP_W-1:0] DIV_RECIP  = 20'd745655;
    localparam int               RECIP_SHIFT  = 25;
    localparam int               Y_W          = U_W + RECIP_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic release_all;
    } job_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
    } pulse_cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              dir_neg;
        logic signed [8:0] offset;
        logic [7:0]        lo;
        logic [7:0]        hi;
    } cal_row_t;

    function automatic cal_row_t cal_row(input logic [JOINT_W-1:0] idx);
        cal_row_t r;
        r.chan    = idx;
        r.dir_neg = 1'b0;
        r.offset  = 9'sd0;
        r.lo      = 8'd0;
        r.hi      = 8'd180;
        unique case (idx)
            4'd0, 4'd3:         begin r.lo = 8'd45; r.hi = 8'd135; end
            4'd6, 4'd9:         begin r.lo = 8'd45; r.hi = 8'd135; r.dir_neg = 1'b1; end
            4'd1, 4'd4, 4'd7, 4'd10: begin r.lo = 8'd50; r.hi = 8'd115; end
            4'd2, 4'd5, 4'd8, 4'd11: begin r.lo = 8'd5;  r.hi = 8'd180; end
            default:            begin r.lo = 8'd0;  r.hi = 8'd180; end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/svpm_front.sv
// Front end: accepts items, keeps joint angles, command age and watchdog trip.
`default_nettype none
module svpm_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire logic [svpm_pkg::OP_W-1:0]           op,
    input  wire logic [svpm_pkg::JOINT_W-1:0]        joint,
    input  wire logic signed [svpm_pkg::ANGLE_W-1:0] angle,
    input  wire logic                                msg_end,
    input  wire logic [svpm_pkg::AGE_W-1:0]          timeout_ms,
    input  wire logic                                busy,
    input  wire logic                                q_full,
    output logic                                     push,
    output svpm_pkg::job_t                           push_job,
    input  wire logic [svpm_pkg::JOINT_W-1:0]        rd_idx,
    output logic signed [svpm_pkg::ANGLE_W-1:0]      rd_angle
);

    logic signed [svpm_pkg::ANGLE_W-1:0] angles_reg [svpm_pkg::JOINT_COUNT];
    logic [svpm_pkg::AGE_W-1:0]          age_reg;
    logic [svpm_pkg::AGE_W-1:0]          age_next;
    logic                                tripped_reg;
    logic                                tripped_next;
    logic                                accept;
    logic                                is_cmd;

    assign is_cmd    = (op == svpm_pkg::OP_CMD);
    assign cmd_ready = !q_full && !(is_cmd && busy);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        age_next         = age_reg;
        tripped_next     = tripped_reg;
        push             = 1'b0;
        push_job.release_all = 1'b0;
        if (accept)
        begin
            case (svpm_pkg::op_t'(op))
                svpm_pkg::OP_CMD:
                begin
                    if (msg_end)
                    begin
                        age_next     = '0;
                        tripped_next = 1'b0;
                    end
                end
                svpm_pkg::OP_TICK:
                begin
                    if (age_reg != svpm_pkg::AGE_MAX)
                    begin
                        age_next = age_reg + 1'b1;
                    end
                end
                svpm_pkg::OP_CTRL:
                begin
                    if (age_reg > timeout_ms)
                    begin
                        if (!tripped_reg)
                        begin
                            tripped_next         = 1'b1;
                            push                 = 1'b1;
                            push_job.release_all = 1'b1;
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                default:
                begin
                    age_next = age_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg     <= svpm_pkg::AGE_MAX;
            tripped_reg <= 1'b1;
            for (int i = 0; i < svpm_pkg::JOINT_COUNT; i++)
            begin
                angles_reg[i] <= '0;
            end
        end
        else
        begin
            age_reg     <= age_next;
            tripped_reg <= tripped_next;
            for (int i = 0; i < svpm_pkg::JOINT_COUNT; i++)
            begin
                if (accept && is_cmd && joint == svpm_pkg::JOINT_W'(i))
                begin
                    angles_reg[i] <= angle;
                end
            end
        end
    end

    always_comb
    begin
        rd_angle = '0;
        for (int i = 0; i < svpm_pkg::JOINT_COUNT; i++)
        begin
            if (rd_idx == svpm_pkg::JOINT_W'(i))
            begin
                rd_angle = angles_reg[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/svpm_queue.sv
// Short job queue between the front end and the pulse pipeline.
`default_nettype none
module svpm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  svpm_pkg::job_t      push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output svpm_pkg::job_t      head
);

    svpm_pkg::job_t                entries_reg [svpm_pkg::QDEPTH];
    logic [svpm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [svpm_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [svpm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [svpm_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [svpm_pkg::QCNT_W-1:0]   count_reg;
    logic [svpm_pkg::QCNT_W-1:0]   count_next;

    assign full      = (count_reg == svpm_pkg::QCNT_W'(svpm_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == svpm_pkg::QPTR_W'(svpm_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == svpm_pkg::QPTR_W'(svpm_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/svpm_back.sv
// Back end: walks the joints of a job, or one release item, through the pulse pipeline into the result register.
`default_nettype none
module svpm_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_not_empty,
    input  svpm_pkg::job_t                           q_head,
    output logic                                     pop,
    output logic [svpm_pkg::JOINT_W-1:0]             rd_idx,
    input  wire logic signed [svpm_pkg::ANGLE_W-1:0] rd_angle,
    input  svpm_pkg::pulse_cfg_t                     cfg,
    output logic                                     busy,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic                                     kind,
    output logic [svpm_pkg::CHAN_W-1:0]              channel,
    output logic [svpm_pkg::PULSE_W-1:0]             pulse_us,
    output logic                                     burst_end
);

    typedef struct packed {
        logic                        rel;
        logic                        last;
        logic [svpm_pkg::CHAN_W-1:0] chan;
    } tag_t;

    logic                          adv;
    logic                          active_reg;
    logic                          active_next;
    logic [svpm_pkg::JOINT_W-1:0]  idx_reg;
    logic [svpm_pkg::JOINT_W-1:0]  idx_next;
    logic                          issue_valid;
    tag_t                          issue_tag;
    svpm_pkg::cal_row_t            row;

    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    tag_t                          s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    svpm_pkg::cal_row_t            s1_row_reg;
    logic signed [svpm_pkg::PROD_W-1:0] s1_prod_reg;
    logic signed [svpm_pkg::PROD_W-1:0] s1_prod_next;
    logic [svpm_pkg::DEG_W-1:0]    s2_deg_reg;
    logic [svpm_pkg::DEG_W-1:0]    s2_deg_next;
    logic signed [svpm_pkg::X_W-1:0] s3_x_reg;
    logic signed [svpm_pkg::X_W-1:0] s3_x_next;
    logic [svpm_pkg::Y_W-1:0]      s4_y_reg;
    logic [svpm_pkg::Y_W-1:0]      s4_y_next;

    logic signed [9:0]                  base_deg;
    logic signed [svpm_pkg::SUM_W-1:0]  sum;
    logic signed [svpm_pkg::SUM_W-1:0]  lo_s;
    logic signed [svpm_pkg::SUM_W-1:0]  hi_s;
    logic signed [svpm_pkg::SUM_W-1:0]  clamped;
    logic signed [svpm_pkg::SPAN_W-1:0] span;
    logic signed [svpm_pkg::X_W-1:0]    shifted;
    logic [svpm_pkg::QV_W-1:0]          biased;
    logic [svpm_pkg::U_W-1:0]           u;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_kind_reg;
    logic [svpm_pkg::CHAN_W-1:0]   out_chan_reg;
    logic [svpm_pkg::PULSE_W-1:0]  out_pulse_reg;
    logic [svpm_pkg::PULSE_W-1:0]  out_pulse_next;
    logic                          out_last_reg;

    assign adv  = !out_valid_reg || res_ready;
    assign busy = active_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg
                || s4_valid_reg || out_valid_reg;

    // job sequencer
    always_comb
    begin
        issue_valid    = 1'b0;
        issue_tag.rel  = 1'b0;
        issue_tag.last = 1'b0;
        rd_idx         = active_reg ? idx_reg : '0;
        row            = svpm_pkg::cal_row(rd_idx);
        issue_tag.chan = row.chan;
        active_next    = active_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (adv)
        begin
            if (active_reg)
            begin
                issue_valid    = 1'b1;
                issue_tag.last = (idx_reg == svpm_pkg::JOINT_W'(svpm_pkg::JOINT_COUNT - 1));
                idx_next       = idx_reg + 1'b1;
                if (issue_tag.last)
                begin
                    active_next = 1'b0;
                end
            end
            else if (q_not_empty)
            begin
                pop         = 1'b1;
                issue_valid = 1'b1;
                if (q_head.release_all)
                begin
                    issue_tag.rel  = 1'b1;
                    issue_tag.last = 1'b1;
                end
                else
                begin
                    issue_tag.last = (svpm_pkg::JOINT_COUNT == 1);
                    active_next    = (svpm_pkg::JOINT_COUNT > 1);
                    idx_next       = svpm_pkg::JOINT_W'(1);
                end
            end
        end
    end

    assign s1_prod_next   = svpm_pkg::PROD_W'(rd_angle)
                          * svpm_pkg::PROD_W'(svpm_pkg::RAD_TO_DEG_Q16);

    // degrees, then clamp to the joint limits
    always_comb
    begin
        base_deg = 10'(svpm_pkg::CENTER_DEG) + 10'(s1_row_reg.offset);
        sum      = (svpm_pkg::SUM_W'(base_deg) <<< svpm_pkg::DEG_FRAC)
                 + (s1_row_reg.dir_neg ? -svpm_pkg::SUM_W'(s1_prod_reg)
                                       :  svpm_pkg::SUM_W'(s1_prod_reg));
        lo_s     = $signed(svpm_pkg::SUM_W'({s1_row_reg.lo, {svpm_pkg::DEG_FRAC{1'b0}}}));
        hi_s     = $signed(svpm_pkg::SUM_W'({s1_row_reg.hi, {svpm_pkg::DEG_FRAC{1'b0}}}));
        clamped  = sum;
        if (sum < lo_s)
        begin
            clamped = lo_s;
        end
        else if (sum > hi_s)
        begin
            clamped = hi_s;
        end
        s2_deg_next = svpm_pkg::DEG_W'(clamped);
    end

    assign span      = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    assign s3_x_next = svpm_pkg::X_W'($signed({1'b0, s2_deg_reg})) * svpm_pkg::X_W'(span);

    assign shifted   = s3_x_reg >>> svpm_pkg::DEG_FRAC;
    assign biased    = svpm_pkg::QV_W'(shifted) + svpm_pkg::DIV_BIAS;
    assign u         = biased[svpm_pkg::QV_W-1:svpm_pkg::DIV_PRESHIFT];
    assign s4_y_next = svpm_pkg::Y_W'(u) * svpm_pkg::Y_W'(svpm_pkg::DIV_RECIP);

    assign out_pulse_next = cfg.pulse_min + s4_y_reg[svpm_pkg::RECIP_SHIFT +: svpm_pkg::PULSE_W];
    assign out_valid_next = adv ? s4_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s1_valid_reg <= issue_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg  <= issue_tag;
            s1_row_reg  <= row;
            s1_prod_reg <= s1_prod_next;
            s2_tag_reg  <= s1_tag_reg;
            s2_deg_reg  <= s2_deg_next;
            s3_tag_reg  <= s2_tag_reg;
            s3_x_reg    <= s3_x_next;
            s4_tag_reg  <= s3_tag_reg;
            s4_y_reg    <= s4_y_next;
            out_kind_reg  <= s4_tag_reg.rel;
            out_chan_reg  <= s4_tag_reg.rel ? '0 : s4_tag_reg.chan;
            out_pulse_reg <= s4_tag_reg.rel ? '0 : out_pulse_next;
            out_last_reg  <= s4_tag_reg.last;
        end
    end

    assign res_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign channel   = out_chan_reg;
    assign pulse_us  = out_pulse_reg;
    assign burst_end = out_last_reg;

endmodule
`default_nettype wire

FILE: design/servo_pulse_mapper_with_watchdog_top.sv
// Top level: configuration registers and wiring of front end, job queue and pulse pipeline.
// A command item waits while a control job is queued or still in the pulse pipeline.
// A control update passes the job queue, stages s1 to s4 and the output register, then gives one
// result per cycle while res_ready does not stall the output: twelve pulses, set by the one-joint-per-cycle walk.
// A watchdog release gives one result through the same queue and stages.
// Reset: age saturated, watchdog tripped, angles zero, registers at their defaults.
`default_nettype none
module servo_pulse_mapper_with_watchdog_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [svpm_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [svpm_pkg::DATA_W-1:0]         pwdata,
    output logic [svpm_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire logic [svpm_pkg::OP_W-1:0]           op,
    input  wire logic [svpm_pkg::JOINT_W-1:0]        joint,
    input  wire logic signed [svpm_pkg::ANGLE_W-1:0] angle,
    input  wire logic                                msg_end,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic                                     kind,
    output logic [svpm_pkg::CHAN_W-1:0]              channel,
    output logic [svpm_pkg::PULSE_W-1:0]             pulse_us,
    output logic                                     burst_end
);

    logic [svpm_pkg::AGE_W-1:0]   timeout_reg;
    logic [svpm_pkg::PULSE_W-1:0] pulse_min_reg;
    logic [svpm_pkg::PULSE_W-1:0] pulse_max_reg;
    logic                         wr_en;
    logic [1:0]                   reg_idx;
    svpm_pkg::pulse_cfg_t         cfg;

    logic                                push;
    svpm_pkg::job_t                      push_job;
    logic                                pop;
    logic                                q_full;
    logic                                q_not_empty;
    svpm_pkg::job_t                      q_head;
    logic                                back_busy;
    logic                                busy;
    logic [svpm_pkg::JOINT_W-1:0]        rd_idx;
    logic signed [svpm_pkg::ANGLE_W-1:0] rd_angle;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= svpm_pkg::TIMEOUT_RST;
            pulse_min_reg <= svpm_pkg::PULSE_MIN_RST;
            pulse_max_reg <= svpm_pkg::PULSE_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                svpm_pkg::REG_TIMEOUT:   timeout_reg   <= pwdata[svpm_pkg::AGE_W-1:0];
                svpm_pkg::REG_PULSE_MIN: pulse_min_reg <= pwdata[svpm_pkg::PULSE_W-1:0];
                svpm_pkg::REG_PULSE_MAX: pulse_max_reg <= pwdata[svpm_pkg::PULSE_W-1:0];
                default:                 timeout_reg   <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            svpm_pkg::REG_TIMEOUT:   prdata = svpm_pkg::DATA_W'(timeout_reg);
            svpm_pkg::REG_PULSE_MIN: prdata = svpm_pkg::DATA_W'(pulse_min_reg);
            svpm_pkg::REG_PULSE_MAX: prdata = svpm_pkg::DATA_W'(pulse_max_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.pulse_min = pulse_min_reg;
    assign cfg.pulse_max = pulse_max_reg;
    assign busy          = q_not_empty || back_busy;

    svpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .op         (op),
        .joint      (joint),
        .angle      (angle),
        .msg_end    (msg_end),
        .timeout_ms (timeout_reg),
        .busy       (busy),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job),
        .rd_idx     (rd_idx),
        .rd_angle   (rd_angle)
    );

    svpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    svpm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .rd_idx      (rd_idx),
        .rd_angle    (rd_angle),
        .cfg         (cfg),
        .busy        (back_busy),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .channel     (channel),
        .pulse_us    (pulse_us),
        .burst_end   (burst_end)
    );

endmodule
`default_nettype wire
